// ===== hdl/cwt_pkg.sv =====
// Shared types, constants and helpers for the command word tokenizer.
// No dependencies.
package cwt_pkg;

  localparam int MAX_FRAC_DIGITS = 9;
  localparam int FRAC_W = 4;
  localparam int MAG_W = 31;
  localparam int MANT_W = 32;
  localparam int LETTER_W = 7;

  localparam logic [MAG_W-1:0] MAG_LIMIT = 31'h7FFF_FFFF;
  localparam logic [FRAC_W-1:0] FRAC_MAX = FRAC_W'(MAX_FRAC_DIGITS);

  localparam logic [1:0] MODE_SEEK   = 2'd0;
  localparam logic [1:0] MODE_NUMBER = 2'd1;
  localparam logic [1:0] MODE_IGNORE = 2'd2;

  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_POINT = 8'h2E;
  localparam logic [7:0] CH_0     = 8'h30;
  localparam logic [7:0] CH_9     = 8'h39;
  localparam logic [7:0] CH_A     = 8'h41;
  localparam logic [7:0] CH_Z     = 8'h5A;

  typedef struct packed {
    logic                       word_valid;
    logic [LETTER_W-1:0]        word_letter;
    logic signed [MANT_W-1:0]   mantissa;
    logic [FRAC_W-1:0]          frac_digits;
    logic                       overflow;
    logic                       line_end;
  } result_t;

  // largest magnitude that may still take digit d without passing the limit
  function automatic logic [MAG_W-1:0] digit_bound(input logic [3:0] d);
    logic [MAG_W-1:0] b;
    b = (d >= 4'd8) ? MAG_W'(214748363) : MAG_W'(214748364);
    return b;
  endfunction

endpackage

// ===== hdl/cwt_in_stage.sv =====
// Input register for one character word.
// Depends on nothing beyond its ports.
module cwt_in_stage (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_char_byte,
  input  logic       drain_ok,
  output logic       full,
  output logic [7:0] char_q
);

  logic       full_r;
  logic       full_nxt;
  logic [7:0] char_r;

  assign in_ready = !full_r || drain_ok;
  assign full     = full_r;
  assign char_q   = char_r;

  always_comb begin
    full_nxt = full_r;
    if (in_valid && in_ready) begin
      full_nxt = 1'b1;
    end else if (drain_ok) begin
      full_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      full_r <= 1'b0;
    end else begin
      full_r <= full_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      char_r <= in_char_byte;
    end
  end

endmodule

// ===== hdl/cwt_parser.sv =====
// Parse state registers and the per-character update logic.
// Depends on cwt_pkg.
module cwt_parser (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            advance,
  input  logic [7:0]      char_q,
  output logic            produce,
  output cwt_pkg::result_t result
);
  import cwt_pkg::*;

  logic [1:0]          mode_r, mode_nxt;
  logic [LETTER_W-1:0] letter_r, letter_nxt;
  logic [MAG_W-1:0]    mag_r, mag_nxt;
  logic [FRAC_W-1:0]   frac_r, frac_nxt;
  logic                skip_r, skip_nxt;
  logic                plus_r, plus_nxt;
  logic                minus_r, minus_nxt;
  logic                point_r, point_nxt;
  logic                used_r, used_nxt;
  logic                sat_r, sat_nxt;

  logic                is_digit;
  logic                is_letter;
  logic [3:0]          dval;
  logic [MAG_W+3:0]    mag_x10;
  logic                taken;
  logic                rescan;

  assign is_digit  = (char_q >= CH_0) && (char_q <= CH_9);
  assign is_letter = (char_q >= CH_A) && (char_q <= CH_Z);
  assign dval      = 4'(char_q - CH_0);
  assign mag_x10   = {mag_r, 3'b000} + {2'b00, mag_r, 1'b0} + {30'd0, dval};

  always_comb begin
    mode_nxt   = mode_r;
    letter_nxt = letter_r;
    mag_nxt    = mag_r;
    frac_nxt   = frac_r;
    skip_nxt   = skip_r;
    plus_nxt   = plus_r;
    minus_nxt  = minus_r;
    point_nxt  = point_r;
    used_nxt   = used_r;
    sat_nxt    = sat_r;
    result     = '0;
    produce    = 1'b0;
    taken      = 1'b0;
    rescan     = 1'b0;

    unique case (mode_r)
      MODE_IGNORE: begin
        if (char_q == CH_NUL) begin
          mode_nxt = MODE_SEEK;
        end
      end
      MODE_NUMBER: begin
        if (char_q == CH_NUL) begin
          mode_nxt        = MODE_SEEK;
          produce         = 1'b1;
          result.line_end = 1'b1;
        end else begin
          if (char_q == CH_PLUS) begin
            if (skip_r && !plus_r) begin
              plus_nxt = 1'b1;
              skip_nxt = 1'b0;
              taken    = 1'b1;
            end
          end else if (char_q == CH_MINUS && skip_r && !minus_r) begin
            minus_nxt = 1'b1;
            skip_nxt  = 1'b0;
            taken     = 1'b1;
          end else if (char_q == CH_POINT) begin
            if (!point_r) begin
              point_nxt = 1'b1;
              taken     = 1'b1;
            end
          end else if (is_digit) begin
            skip_nxt = 1'b0;
            taken    = 1'b1;
            if (!(point_r && frac_r >= FRAC_MAX) && !sat_r) begin
              if (mag_r > digit_bound(dval)) begin
                mag_nxt = MAG_LIMIT;
                sat_nxt = 1'b1;
              end else begin
                mag_nxt = mag_x10[MAG_W-1:0];
                if (point_r) begin
                  frac_nxt = frac_r + FRAC_W'(1);
                end
              end
            end
          end else if (skip_r) begin
            taken = 1'b1;
          end
          if (taken) begin
            used_nxt = 1'b1;
          end else begin
            produce  = 1'b1;
            mode_nxt = MODE_SEEK;
            rescan   = 1'b1;
          end
        end
        if (produce && (taken || used_r || char_q != CH_NUL)) begin
          result.word_valid  = 1'b1;
          result.word_letter = letter_r;
          result.mantissa    = minus_r ? -$signed({1'b0, mag_r}) : $signed({1'b0, mag_r});
          result.frac_digits = frac_r;
          result.overflow    = sat_r;
        end
      end
      MODE_SEEK: begin
        if (char_q == CH_NUL) begin
          produce         = 1'b1;
          result.line_end = 1'b1;
        end else begin
          rescan = 1'b1;
        end
      end
      default: begin
        mode_nxt = MODE_SEEK;
      end
    endcase

    if (rescan) begin
      if (char_q == CH_SPACE) begin
        mode_nxt = MODE_SEEK;
      end else if (is_letter) begin
        mode_nxt   = MODE_NUMBER;
        letter_nxt = char_q[LETTER_W-1:0];
        mag_nxt    = '0;
        frac_nxt   = '0;
        skip_nxt   = 1'b1;
        plus_nxt   = 1'b0;
        minus_nxt  = 1'b0;
        point_nxt  = 1'b0;
        used_nxt   = 1'b0;
        sat_nxt    = 1'b0;
      end else begin
        mode_nxt        = MODE_IGNORE;
        produce         = 1'b1;
        result.line_end = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r   <= MODE_SEEK;
      letter_r <= '0;
      mag_r    <= '0;
      frac_r   <= '0;
      skip_r   <= 1'b1;
      plus_r   <= 1'b0;
      minus_r  <= 1'b0;
      point_r  <= 1'b0;
      used_r   <= 1'b0;
      sat_r    <= 1'b0;
    end else if (advance) begin
      mode_r   <= mode_nxt;
      letter_r <= letter_nxt;
      mag_r    <= mag_nxt;
      frac_r   <= frac_nxt;
      skip_r   <= skip_nxt;
      plus_r   <= plus_nxt;
      minus_r  <= minus_nxt;
      point_r  <= point_nxt;
      used_r   <= used_nxt;
      sat_r    <= sat_nxt;
    end
  end

endmodule

// ===== hdl/cwt_out_stage.sv =====
// Result register holding one finished word until it is taken.
// Depends on cwt_pkg.
module cwt_out_stage (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             load,
  input  cwt_pkg::result_t result,
  input  logic             out_ready,
  output logic             out_valid,
  output logic             free,
  output cwt_pkg::result_t held
);
  import cwt_pkg::*;

  logic    valid_r, valid_nxt;
  result_t held_r;

  assign out_valid = valid_r;
  assign free      = !valid_r || out_ready;
  assign held      = held_r;

  always_comb begin
    valid_nxt = valid_r;
    if (load) begin
      valid_nxt = 1'b1;
    end else if (out_ready) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      held_r <= result;
    end
  end

endmodule

// ===== hdl/command_word_tokenizer.sv =====
// Command word tokenizer: one character word in, at most one letter-number word out.
// Characters are decoded combinationally from the input register into the output one.
// Throughput: one character per cycle unless out_ready stalls the result register.
// Reset (synchronous, rst_n low) empties both registers and returns to seek mode.
// Depends on cwt_pkg, cwt_in_stage, cwt_parser, cwt_out_stage.
module command_word_tokenizer (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  logic [7:0]                            in_char_byte,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic                                  out_word_valid,
  output logic [cwt_pkg::LETTER_W-1:0]          out_word_letter,
  output logic signed [cwt_pkg::MANT_W-1:0]     out_mantissa,
  output logic [cwt_pkg::FRAC_W-1:0]            out_frac_digits,
  output logic                                  out_overflow,
  output logic                                  out_line_end
);
  import cwt_pkg::*;

  logic       full;
  logic [7:0] char_q;
  logic       out_free;
  logic       advance;
  logic       produce;
  result_t    result;
  result_t    held;

  assign advance = full && out_free;

  cwt_in_stage u_in (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_char_byte (in_char_byte),
    .drain_ok     (out_free),
    .full         (full),
    .char_q       (char_q)
  );

  cwt_parser u_parser (
    .clk     (clk),
    .rst_n   (rst_n),
    .advance (advance),
    .char_q  (char_q),
    .produce (produce),
    .result  (result)
  );

  cwt_out_stage u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (advance && produce),
    .result    (result),
    .out_ready (out_ready),
    .out_valid (out_valid),
    .free      (out_free),
    .held      (held)
  );

  assign out_word_valid  = held.word_valid;
  assign out_word_letter = held.word_letter;
  assign out_mantissa    = held.mantissa;
  assign out_frac_digits = held.frac_digits;
  assign out_overflow    = held.overflow;
  assign out_line_end    = held.line_end;

endmodule

// ===== test/tb_command_word_tokenizer.sv =====
// Self-checking bench for command_word_tokenizer: a directed table, then random command lines.
// Each accepted char runs through an in-bench tokenizer whose words are checked in order.
// Depends on cwt_pkg and the command_word_tokenizer RTL.
module tb_command_word_tokenizer;
  import cwt_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int PHASE_CHARS = 500;
  localparam int SETTLE_CYCLES = 8;
  localparam int MAX_PRINTS = 40;

  localparam logic [7:0] CH_SEMI  = 8'h3B;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_LOW_A = 8'h61;

  typedef struct {
    logic [7:0] ch;
    bit         typed;
    result_t    want;
  } dir_row_t;

  logic                     clk = 1'b0;
  logic                     rst_n = 1'b0;
  logic                     in_valid = 1'b0;
  logic                     in_ready;
  logic [7:0]               in_char_byte = '0;
  logic                     out_valid;
  logic                     out_ready = 1'b0;
  logic                     out_word_valid;
  logic [LETTER_W-1:0]      out_word_letter;
  logic signed [MANT_W-1:0] out_mantissa;
  logic [FRAC_W-1:0]        out_frac_digits;
  logic                     out_overflow;
  logic                     out_line_end;

  // typed expectation riding along with the char that is on the input
  bit      in_typed = 1'b0;
  result_t in_typed_word = '0;

  int send_idle_pct = 0;
  int stall_pct = 0;
  int err_count = 0;
  int accepted_chars = 0;
  int live_chars = 0;
  int cycle_count = 0;
  result_t words_due [$];
  dir_row_t dir_table [25];

  // tokenizer state
  logic [1:0]        tok_mode = MODE_SEEK;
  logic [7:0]        tok_letter = '0;
  logic [MAG_W-1:0]  tok_mag = '0;
  logic [FRAC_W-1:0] tok_frac = '0;
  bit                tok_skipping = 1'b1;
  bit                tok_plus = 1'b0;
  bit                tok_minus = 1'b0;
  bit                tok_point = 1'b0;
  bit                tok_consumed = 1'b0;
  bit                tok_sat = 1'b0;

  command_word_tokenizer dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_char_byte    (in_char_byte),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_word_valid  (out_word_valid),
    .out_word_letter (out_word_letter),
    .out_mantissa    (out_mantissa),
    .out_frac_digits (out_frac_digits),
    .out_overflow    (out_overflow),
    .out_line_end    (out_line_end)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(negedge clk) begin
    out_ready <= ($urandom_range(0, 99) >= stall_pct);
  end

  function automatic void open_word(input logic [7:0] c);
    tok_mode = MODE_NUMBER;
    tok_letter = c;
    tok_mag = '0;
    tok_frac = '0;
    tok_skipping = 1'b1;
    tok_plus = 1'b0;
    tok_minus = 1'b0;
    tok_point = 1'b0;
    tok_consumed = 1'b0;
    tok_sat = 1'b0;
  endfunction

  // seek handling of a nonzero char; 1 when the line stops here
  function automatic bit seek_stops(input logic [7:0] c);
    if (c == CH_SPACE) return 1'b0;
    if (c >= CH_A && c <= CH_Z) begin
      open_word(c);
      return 1'b0;
    end
    tok_mode = MODE_IGNORE;
    return 1'b1;
  endfunction

  function automatic result_t finished_word();
    result_t r;
    r = '0;
    r.word_valid = 1'b1;
    r.word_letter = tok_letter[LETTER_W-1:0];
    r.mantissa = tok_minus ? -$signed({1'b0, tok_mag}) : $signed({1'b0, tok_mag});
    r.frac_digits = tok_frac;
    r.overflow = tok_sat;
    return r;
  endfunction

  function automatic void absorb_digit(input logic [3:0] d);
    logic [MANT_W-1:0] wide;
    wide = {1'b0, tok_mag};
    if (tok_point && tok_frac >= FRAC_MAX) return;
    if (tok_sat) return;
    if (wide > (MANT_W'(MAG_LIMIT) - MANT_W'(d)) / 32'd10) begin
      tok_mag = MAG_LIMIT;
      tok_sat = 1'b1;
    end else begin
      wide = wide * 32'd10 + MANT_W'(d);
      tok_mag = wide[MAG_W-1:0];
      if (tok_point) tok_frac = tok_frac + FRAC_W'(1);
    end
  endfunction

  // advance the tokenizer by one char; 1 when a result word is due
  function automatic bit tokenize(input logic [7:0] c, output result_t r);
    bit took;
    r = '0;
    took = 1'b0;
    if (tok_mode == MODE_IGNORE) begin
      if (c == CH_NUL) tok_mode = MODE_SEEK;
      return 1'b0;
    end
    if (tok_mode == MODE_SEEK) begin
      if (c == CH_NUL || seek_stops(c)) begin
        r.line_end = 1'b1;
        return 1'b1;
      end
      return 1'b0;
    end
    if (c == CH_NUL) begin
      tok_mode = MODE_SEEK;
      if (tok_consumed) r = finished_word();
      r.line_end = 1'b1;
      return 1'b1;
    end
    if (c == CH_PLUS) begin
      if (tok_skipping && !tok_plus) begin
        tok_plus = 1'b1;
        tok_skipping = 1'b0;
        took = 1'b1;
      end
    end else if (c == CH_MINUS && tok_skipping && !tok_minus) begin
      tok_minus = 1'b1;
      tok_skipping = 1'b0;
      took = 1'b1;
    end else if (c == CH_POINT) begin
      if (!tok_point) begin
        tok_point = 1'b1;
        took = 1'b1;
      end
    end else if (c >= CH_0 && c <= CH_9) begin
      tok_skipping = 1'b0;
      absorb_digit(4'(c - CH_0));
      took = 1'b1;
    end else if (tok_skipping) begin
      took = 1'b1;
    end
    if (took) begin
      tok_consumed = 1'b1;
      return 1'b0;
    end
    // number ends here; the same char is rescanned in seek mode
    r = finished_word();
    tok_mode = MODE_SEEK;
    r.line_end = seek_stops(c);
    return 1'b1;
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    err_count++;
    if (err_count <= MAX_PRINTS)
      $display("ERROR @%0t %s: got 0x%0h, expected 0x%0h", $time, what, got, want);
  endtask

  task automatic check_word(input result_t got, input result_t want);
    if (got.word_valid !== want.word_valid)
      report_mismatch("word_valid", 32'(got.word_valid), 32'(want.word_valid));
    if (got.word_letter !== want.word_letter)
      report_mismatch("word_letter", 32'(got.word_letter), 32'(want.word_letter));
    if (got.mantissa !== want.mantissa)
      report_mismatch("mantissa", got.mantissa, want.mantissa);
    if (got.frac_digits !== want.frac_digits)
      report_mismatch("frac_digits", 32'(got.frac_digits), 32'(want.frac_digits));
    if (got.overflow !== want.overflow)
      report_mismatch("overflow", 32'(got.overflow), 32'(want.overflow));
    if (got.line_end !== want.line_end)
      report_mismatch("line_end", 32'(got.line_end), 32'(want.line_end));
  endtask

  always @(posedge clk) begin : watch_ports
    result_t seen;
    result_t fresh;
    bit has_word;
    if (rst_n) begin
      if (out_valid && out_ready) begin
        seen = {out_word_valid, out_word_letter, out_mantissa, out_frac_digits,
                out_overflow, out_line_end};
        if (words_due.size() == 0) report_mismatch("word with nothing due", 0, 0);
        else check_word(seen, words_due.pop_front());
      end
      if (in_valid && in_ready) begin
        if (tok_mode != MODE_IGNORE) live_chars++;
        has_word = tokenize(in_char_byte, fresh);
        if (in_typed) words_due.push_back(in_typed_word);
        else if (has_word) words_due.push_back(fresh);
        accepted_chars++;
      end
    end
  end

  task automatic send_row(input logic [7:0] c, input bit typed, input result_t want);
    int taken_before;
    taken_before = accepted_chars;
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_char_byte <= c;
    in_typed <= typed;
    in_typed_word <= want;
    do @(negedge clk); while (accepted_chars == taken_before);
  endtask

  task automatic send_char(input logic [7:0] c);
    send_row(c, 1'b0, '0);
  endtask

  task automatic send_digits(input int count);
    repeat (count) send_char(8'(CH_0 + $urandom_range(0, 9)));
  endtask

  task automatic send_random_line();
    if ($urandom_range(0, 9) == 0) begin
      repeat ($urandom_range(1, 6)) send_char(8'($urandom_range(0, 255)));
    end else begin
      repeat ($urandom_range(1, 4)) begin
        send_char(8'(CH_A + $urandom_range(0, 25)));
        if ($urandom_range(0, 9) == 0) send_char(8'($urandom_range(1, 255)));
        case ($urandom_range(0, 3))
          0: send_char(CH_PLUS);
          1: send_char(CH_MINUS);
          default: ;
        endcase
        send_digits(($urandom_range(0, 7) == 0) ? $urandom_range(10, 13) : $urandom_range(0, 6));
        if ($urandom_range(0, 2) == 0) begin
          send_char(CH_POINT);
          send_digits(($urandom_range(0, 7) == 0) ? $urandom_range(9, 12) : $urandom_range(0, 4));
        end
        if ($urandom_range(0, 11) == 0) begin
          case ($urandom_range(0, 2))
            0: send_char(CH_PLUS);
            1: send_char(CH_MINUS);
            default: send_char(CH_POINT);
          endcase
        end
        repeat ($urandom_range(0, 2)) send_char(CH_SPACE);
      end
      if ($urandom_range(0, 3) != 0) begin
        send_char(CH_NUL);
      end else begin
        case ($urandom_range(0, 4))
          0: send_char(CH_SEMI);
          1: send_char(CH_CR);
          2: send_char(CH_LF);
          3: send_char(8'(CH_LOW_A + $urandom_range(0, 25)));
          default: send_char(8'($urandom_range(1, 255)));
        endcase
        repeat ($urandom_range(0, 3)) send_char(8'($urandom_range(1, 255)));
        send_char(CH_NUL);
      end
    end
  endtask

  task automatic drain_words();
    in_valid <= 1'b0;
    @(negedge clk);
    while (words_due.size() != 0) @(negedge clk);
  endtask

  function automatic dir_row_t row(input logic [7:0] c, input bit typed, input result_t want);
    dir_row_t r;
    r.ch = c;
    r.typed = typed;
    r.want = want;
    return r;
  endfunction

  function automatic result_t word_of(input bit v, input logic [7:0] letter,
                                      input logic signed [MANT_W-1:0] m,
                                      input logic [FRAC_W-1:0] f, input bit ovf,
                                      input bit le);
    return {v, letter[LETTER_W-1:0], m, f, ovf, le};
  endfunction

  initial begin : watchdog
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("[FAIL] regression broken");
    $finish;
  end

  initial begin : run
    int send_plan [4] = '{0, 77, 0, 38};
    int stall_plan [4] = '{0, 0, 77, 38};
    int goal;
    dir_table = '{
      row(CH_NUL, 1, word_of(0, CH_NUL, 0, 0, 0, 1)),
      row(CH_Z, 0, '0),
      row(CH_NUL, 1, word_of(0, CH_NUL, 0, 0, 0, 1)),
      row(CH_A, 0, '0),
      row(CH_MINUS, 0, '0),
      row(CH_9, 0, '0), row(CH_9, 0, '0), row(CH_9, 0, '0), row(CH_9, 0, '0),
      row(CH_9, 0, '0), row(CH_9, 0, '0), row(CH_9, 0, '0), row(CH_9, 0, '0),
      row(CH_9, 0, '0), row(CH_9, 0, '0),
      row("C", 1, word_of(1, CH_A, -32'sd2147483647, 0, 1, 0)),
      row(CH_PLUS, 0, '0),
      row("5", 0, '0),
      row(CH_NUL, 1, word_of(1, "C", 5, 0, 0, 1)),
      row("B", 0, '0),
      row("x", 0, '0),
      row(CH_NUL, 1, word_of(1, "B", 0, 0, 0, 1)),
      row("a", 1, word_of(0, CH_NUL, 0, 0, 0, 1)),
      row(8'hFF, 0, '0),
      row(CH_NUL, 0, '0)
    };
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    foreach (dir_table[i]) send_row(dir_table[i].ch, dir_table[i].typed, dir_table[i].want);
    for (int ph = 0; ph < 4; ph++) begin
      send_idle_pct = send_plan[ph];
      stall_pct = stall_plan[ph];
      goal = live_chars + PHASE_CHARS;
      while (live_chars < goal) send_random_line();
      drain_words();
    end
    repeat (SETTLE_CYCLES) @(negedge clk);
    if (err_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

// ===== files.f =====
hdl/cwt_pkg.sv
hdl/cwt_in_stage.sv
hdl/cwt_parser.sv
hdl/cwt_out_stage.sv
hdl/command_word_tokenizer.sv
test/tb_command_word_tokenizer.sv
